// File: rtl/core/program_stream_video_extractor_assert.svh
// Assertion macros used by the extractor RTL.
`ifndef PROGRAM_STREAM_VIDEO_EXTRACTOR_ASSERT_SVH
`define PROGRAM_STREAM_VIDEO_EXTRACTOR_ASSERT_SVH

// Assert a property on every rising clock edge outside of reset.
`define PSVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition in one cycle implies another in the next cycle.
`define PSVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/psve_pkg.sv
// Shared types and constants of the program stream video extractor.
`timescale 1ns / 1ps

package psve_pkg;

  localparam int unsigned PosW = 17;
  localparam int unsigned PackHeaderBytes = 14;
  localparam logic [PosW-1:0] LenUnknown = 17'h1FFFF;

  localparam logic [7:0] IdEnd       = 8'hB9;
  localparam logic [7:0] IdPack      = 8'hBA;
  localparam logic [7:0] IdSysHeader = 8'hBB;
  localparam logic [7:0] IdPsMap     = 8'hBC;
  localparam logic [7:0] IdEcm       = 8'hF1;
  localparam logic [7:0] IdAudioLo   = 8'hC0;
  localparam logic [7:0] IdAudioHi   = 8'hDF;
  localparam logic [7:0] IdVideoLo   = 8'hE0;
  localparam logic [7:0] IdVideoHi   = 8'hEF;
  localparam logic [2:0] StuffMask   = 3'h7;

  typedef enum logic [1:0] {
    KindPack  = 2'd0,
    KindSkip  = 2'd1,
    KindVideo = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] es_byte;
    logic       payload_end;
  } result_t;

endpackage

// File: rtl/core/psve_parser.sv
// Start code hunt and packet walker; one byte per accepted transaction.
`timescale 1ns / 1ps

module psve_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        stream_byte_i,
  input  logic              end_of_buffer_i,
  output logic              res_valid_o,
  output psve_pkg::result_t res_o
);
  import psve_pkg::*;

  localparam logic PhaseHunt = 1'b0;
  localparam logic PhaseItem = 1'b1;

  logic [23:0]     recent_q, recent_d;
  logic [1:0]      fill_q, fill_d;
  logic            phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] total_q, total_d;
  kind_e           kind_q, kind_d;
  logic [7:0]      hdl_q, hdl_d;
  logic [7:0]      lenhi_q, lenhi_d;

  logic [PosW:0]   pos_inc;
  logic [PosW-1:0] payload_start;
  logic            is_start;

  assign pos_inc       = {1'b0, pos_q} + {{PosW{1'b0}}, 1'b1};
  assign payload_start = {{(PosW-8){1'b0}}, hdl_q} + PosW'(9);
  assign is_start      = (fill_q == 2'd3) && (recent_q == 24'h000001);

  always_comb begin
    recent_d    = recent_q;
    fill_d      = fill_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    total_d     = total_q;
    kind_d      = kind_q;
    hdl_d       = hdl_q;
    lenhi_d     = lenhi_q;
    res_valid_o = 1'b0;
    res_o       = '{es_byte: stream_byte_i, payload_end: 1'b0};

    if (accept_i) begin
      if (phase_q == PhaseHunt) begin
        if (is_start && (stream_byte_i == IdPack || stream_byte_i == IdEnd ||
            stream_byte_i == IdSysHeader || stream_byte_i == IdPsMap ||
            stream_byte_i == IdEcm ||
            (stream_byte_i >= IdAudioLo && stream_byte_i <= IdAudioHi) ||
            (stream_byte_i >= IdVideoLo && stream_byte_i <= IdVideoHi))) begin
          recent_d = '0;
          fill_d   = '0;
          if (stream_byte_i != IdEnd) begin
            phase_d = PhaseItem;
            pos_d   = PosW'(4);
            hdl_d   = '0;
            lenhi_d = '0;
            priority if (stream_byte_i == IdPack) begin
              kind_d  = KindPack;
              total_d = PosW'(PackHeaderBytes);
            end else if (stream_byte_i >= IdVideoLo && stream_byte_i <= IdVideoHi) begin
              kind_d  = KindVideo;
              total_d = LenUnknown;
            end else begin
              kind_d  = KindSkip;
              total_d = LenUnknown;
            end
          end
        end else begin
          // Shift the byte into the window, ignored ids included.
          recent_d = {recent_q[15:0], stream_byte_i};
          if (fill_q != 2'd3) begin
            fill_d = fill_q + 2'd1;
          end
        end
      end else begin
        if (kind_q == KindPack) begin
          if (pos_q == PosW'(PackHeaderBytes - 1)) begin
            total_d = PosW'(PackHeaderBytes) + {{(PosW-3){1'b0}}, stream_byte_i[2:0] & StuffMask};
          end
        end else if (pos_q == PosW'(4)) begin
          lenhi_d = stream_byte_i;
        end else if (pos_q == PosW'(5)) begin
          total_d = {1'b0, lenhi_q, stream_byte_i} + PosW'(6);
        end else if (kind_q == KindVideo) begin
          if (pos_q == PosW'(8)) begin
            hdl_d = stream_byte_i;
          end else if (pos_q >= PosW'(9) && pos_q >= payload_start && pos_q < total_q) begin
            res_valid_o       = 1'b1;
            res_o.payload_end = (pos_inc == {1'b0, total_q});
          end
        end
        // The length may have been learned on this very byte.
        if (pos_inc >= {1'b0, total_d}) begin
          phase_d  = PhaseHunt;
          recent_d = '0;
          fill_d   = '0;
        end else begin
          pos_d = pos_inc[PosW-1:0];
        end
      end

      if (end_of_buffer_i) begin
        recent_d = '0;
        fill_d   = '0;
        phase_d  = PhaseHunt;
        pos_d    = '0;
        total_d  = '0;
        kind_d   = KindPack;
        hdl_d    = '0;
        lenhi_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      fill_q   <= '0;
      phase_q  <= PhaseHunt;
      pos_q    <= '0;
      total_q  <= '0;
      kind_q   <= KindPack;
      hdl_q    <= '0;
      lenhi_q  <= '0;
    end else begin
      recent_q <= recent_d;
      fill_q   <= fill_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      kind_q   <= kind_d;
      hdl_q    <= hdl_d;
      lenhi_q  <= lenhi_d;
    end
  end

endmodule

// File: rtl/core/psve_out_buf.sv
// Result register with a skid stage behind it.
`timescale 1ns / 1ps
`include "program_stream_video_extractor_assert.svh"

module psve_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psve_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output psve_pkg::result_t out_data_o,
  input  logic              out_ready_i
);
  import psve_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop         = out_valid_q && out_ready_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // Drain the skid stage into the result register.
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  `PSVE_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full with empty output")
  `PSVE_ASSERT(a_no_push_when_full, !(push_i && skid_valid_q), "push into a full buffer")
  `PSVE_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready_i, !skid_valid_q && out_valid_q,
                    "skid stage did not drain")
  `PSVE_ASSERT_NEXT(a_stall_holds, out_valid_q && !out_ready_i,
                    out_valid_q && out_data_q == $past(out_data_q), "stalled result changed")

endmodule

// File: rtl/core/program_stream_video_extractor.sv
// Payload bytes go to the result register, or to the skid stage while that register stalls.
// Throughput: one input byte per cycle while the skid stage is empty; one parser pass per byte.
// A result register plus a one-entry skid stage keep input flowing while a result waits.
// Input ready drops only while the skid stage holds a result.
// Reset (rst_ni low, asynchronous) returns the parser to start-code hunt and empties buffers.
`timescale 1ns / 1ps

module program_stream_video_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic       end_of_buffer_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] es_byte_o,
  output logic       payload_end_o
);
  import psve_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // Take a byte whenever the skid stage has room; the parser never stalls.
  assign accept = in_valid_i && in_ready_o;

  // Walk the stream: hunt start codes, skip non-video items, pick out video payload.
  psve_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .stream_byte_i  (stream_byte_i),
    .end_of_buffer_i(end_of_buffer_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Hold payload bytes until the downstream transaction completes.
  psve_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data),
    .out_ready_i(out_ready_i)
  );

  assign es_byte_o     = out_data.es_byte;
  assign payload_end_o = out_data.payload_end;

endmodule

// File: dv/tb_program_stream_video_extractor.sv
// Self-checking testbench of the program stream video extractor.
`timescale 1ns / 1ps

module tb_program_stream_video_extractor;
  import psve_pkg::*;

  // How the input monitor builds the expectation of a transaction.
  typedef enum logic [1:0] {
    ChkPredict,  // take whatever the parser predictor says
    ChkNone,     // typed in: the byte yields no payload byte
    ChkResult    // typed in: the byte yields the payload byte in the row
  } chk_e;

  typedef struct {
    logic [7:0] b;
    logic       eob;
    chk_e       mode;
    logic [7:0] xb;
    logic       xe;
  } dir_row_t;

  typedef struct {
    logic [7:0] b;
    logic       eob;
  } stim_t;

  localparam logic [23:0] StartCode  = 24'h000001;
  localparam int          RandItems  = 1600;
  localparam int          StallLimit = 2000;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic [7:0] stream_byte_i   = 8'h00;
  logic       end_of_buffer_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [7:0] es_byte_o;
  logic       payload_end_o;

  // Row tag that travels with the payload, so the input monitor knows
  // whether the expectation is typed in or predicted.
  chk_e       row_mode = ChkPredict;
  logic [7:0] row_xb   = 8'h00;
  logic       row_xe   = 1'b0;

  // Stretch with no idling on either side.
  logic calm = 1'b0;

  result_t  es_expected[$];
  dir_row_t dir_rows[$];
  stim_t    unit_q[$];

  int n_err    = 0;
  int n_bytes  = 0;
  int n_eob    = 0;
  int n_es     = 0;
  int n_dir    = 0;
  int stall_cnt = 0;

  program_stream_video_extractor DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .stream_byte_i   (stream_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .es_byte_o       (es_byte_o),
    .payload_end_o   (payload_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Parser predictor: own copy of the demux state at the block's widths.
  // ---------------------------------------------------------------------
  logic [23:0]    win;
  logic [1:0]     win_fill;
  bit             in_item;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] tot_len;
  kind_e          kind;
  logic [7:0]     hdr_len;
  logic [7:0]     len_hi;

  // Go back to start-code hunting with an empty window.
  function automatic void start_hunt();
    in_item  = 1'b0;
    win      = '0;
    win_fill = '0;
  endfunction

  function automatic void reset_parser();
    start_hunt();
    pos     = '0;
    tot_len = '0;
    kind    = KindPack;
    hdr_len = '0;
    len_hi  = '0;
  endfunction

  // Enter an item right after its stream id; the id sits at offset 3.
  function automatic void open_item(input kind_e k, input logic [PosW-1:0] total);
    in_item  = 1'b1;
    kind     = k;
    pos      = PosW'(4);
    tot_len  = total;
    hdr_len  = '0;
    len_hi   = '0;
    win      = '0;
    win_fill = '0;
  endfunction

  function automatic void shift_window(input logic [7:0] b);
    win = {win[15:0], b};
    if (win_fill != 2'd3) win_fill = win_fill + 2'd1;
  endfunction

  // Advance the predictor by one stream byte; return 1 with the payload
  // byte in res when the byte belongs to a video payload.
  function automatic bit step_parser(input logic [7:0] b, input logic eob,
                                     output result_t res);
    bit          emit;
    logic [17:0] p_next;
    emit = 1'b0;
    res  = '0;
    if (!in_item) begin
      if (win_fill == 2'd3 && win == StartCode) begin
        if (b == IdPack) begin
          open_item(KindPack, PosW'(PackHeaderBytes));
        end else if (b == IdEnd) begin
          start_hunt();
        end else if (b == IdSysHeader || b == IdPsMap || b == IdEcm ||
                     (b >= IdAudioLo && b <= IdAudioHi)) begin
          open_item(KindSkip, LenUnknown);
        end else if (b >= IdVideoLo && b <= IdVideoHi) begin
          open_item(KindVideo, LenUnknown);
        end else begin
          // Unhandled id: keep it in the window and keep hunting.
          shift_window(b);
        end
      end else begin
        shift_window(b);
      end
    end else begin
      p_next = {1'b0, pos} + 18'd1;
      if (kind == KindPack) begin
        // Last fixed pack header byte carries the stuffing count.
        if (pos == PosW'(PackHeaderBytes - 1))
          tot_len = PosW'(PackHeaderBytes) + PosW'(b & 8'(StuffMask));
      end else begin
        if (pos == PosW'(4)) begin
          len_hi = b;
        end else if (pos == PosW'(5)) begin
          tot_len = PosW'(6) + PosW'({len_hi, b});
        end else if (kind == KindVideo) begin
          if (pos == PosW'(8)) begin
            hdr_len = b;
          end else if (pos >= PosW'(9) && {1'b0, pos} >= 18'd9 + hdr_len &&
                       pos < tot_len) begin
            emit            = 1'b1;
            res.es_byte     = b;
            res.payload_end = (p_next == {1'b0, tot_len});
          end
        end
      end
      if (p_next >= {1'b0, tot_len}) start_hunt();
      else pos = p_next[PosW-1:0];
    end
    if (eob) reset_parser();
    return emit;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors, sampled at the rising edge on pre-edge values.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_monitor
    result_t r;
    bit      got;
    if (in_valid_i && in_ready_o) begin
      got = step_parser(stream_byte_i, end_of_buffer_i, r);
      n_bytes++;
      if (end_of_buffer_i) n_eob++;
      case (row_mode)
        ChkPredict: if (got) es_expected.push_back(r);
        ChkResult: begin
          r.es_byte     = row_xb;
          r.payload_end = row_xe;
          es_expected.push_back(r);
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : es_monitor
    result_t want;
    if (out_valid_o && out_ready_i) begin
      n_es++;
      if (es_expected.size() == 0) begin
        $error("payload byte with none expected: es_byte %02h payload_end %0b",
               es_byte_o, payload_end_o);
        n_err++;
      end else begin
        want = es_expected.pop_front();
        if (want.es_byte !== es_byte_o) begin
          $error("es_byte: expected %02h, actual %02h", want.es_byte, es_byte_o);
          n_err++;
        end
        if (want.payload_end !== payload_end_o) begin
          $error("payload_end: expected %0b, actual %0b",
                 want.payload_end, payload_end_o);
          n_err++;
        end
      end
    end
  end

  // Drop ready about 29 percent of the time, except in the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 29);
  end

  // End the run when no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("Timeout: no transaction for %0d cycles", StallLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic add_row(input logic [7:0] b, input logic eob, input chk_e mode,
                         input logic [7:0] xb = 8'h00, input logic xe = 1'b0);
    dir_row_t row;
    row.b    = b;
    row.eob  = eob;
    row.mode = mode;
    row.xb   = xb;
    row.xe   = xe;
    dir_rows.push_back(row);
  endtask

  // Present one byte and hold it until the block takes it.
  task automatic send_item(input logic [7:0] b, input logic eob, input chk_e mode,
                           input logic [7:0] xb, input logic xe);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    stream_byte_i   <= b;
    end_of_buffer_i <= eob;
    row_mode        <= mode;
    row_xb          <= xb;
    row_xe          <= xe;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold the input off until every expected payload byte has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (es_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b);
    stim_t s;
    s.b   = b;
    s.eob = 1'b0;
    unit_q.push_back(s);
  endtask

  task automatic push_start(input logic [7:0] id);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(id);
  endtask

  // Build one stream unit: mostly well-formed packets with random content,
  // the rest end codes, ignored ids, noise and packets cut by a buffer end.
  task automatic gen_unit();
    int         pick;
    int         r;
    int         len;
    int         hdr;
    int         n;
    int         cut;
    int         stop;
    bit         force_cut;
    logic [7:0] id;
    logic [7:0] last;
    unit_q.delete();
    force_cut = 1'b0;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // Video PES: very short, long with extreme header length, huge, usual.
      id = IdVideoLo + 8'($urandom_range(15));
      r  = $urandom_range(99);
      if (r < 8) len = $urandom_range(3);
      else if (r < 12) len = $urandom_range(258, 278);
      else if (r < 16) begin
        len       = $urandom_range(16'hFFFF);
        force_cut = 1'b1;
      end else len = $urandom_range(3, 40);
      if (len >= 258 && !force_cut) hdr = $urandom_range(250, 255);
      else if ($urandom_range(99) < 15) hdr = $urandom_range(255);
      else hdr = (len > 3) ? $urandom_range(len - 3) : 0;
      push_start(id);
      push_byte(8'(len >> 8));
      push_byte(8'(len));
      stop = force_cut ? 70 : 6 + len;
      for (n = 6; n < stop; n++) begin
        if (n == 8) push_byte(8'(hdr));
        else push_byte(8'($urandom));
      end
    end else if (pick < 60) begin
      // Skipped packet: audio, system header, stream map or ECM.
      r = $urandom_range(3);
      if (r == 0) id = IdSysHeader;
      else if (r == 1) id = IdPsMap;
      else if (r == 2) id = IdEcm;
      else id = IdAudioLo + 8'($urandom_range(31));
      if ($urandom_range(99) < 6) begin
        len       = $urandom_range(16'hFFFF);
        force_cut = 1'b1;
      end else len = $urandom_range(24);
      push_start(id);
      push_byte(8'(len >> 8));
      push_byte(8'(len));
      stop = force_cut ? 60 : 6 + len;
      for (n = 6; n < stop; n++) push_byte(8'($urandom));
    end else if (pick < 72) begin
      // Pack header plus its stuffing bytes.
      push_start(IdPack);
      for (n = 4; n < PackHeaderBytes - 1; n++) push_byte(8'($urandom));
      last = 8'($urandom);
      push_byte(last);
      for (n = 0; n < int'(last & 8'(StuffMask)); n++) push_byte(8'($urandom));
    end else if (pick < 78) begin
      push_start(IdEnd);
    end else if (pick < 88) begin
      // Start code followed by an id the parser does not handle.
      r = $urandom_range(3);
      if (r == 0) id = 8'($urandom_range(IdEnd - 1));
      else if (r == 1) id = 8'($urandom_range(8'hBD, 8'hBF));
      else if (r == 2) id = 8'hF0;
      else id = 8'($urandom_range(8'hF2, 8'hFF));
      push_start(id);
    end else begin
      // Noise biased toward zeros and ones, to build broken start codes.
      stop = $urandom_range(1, 6);
      for (n = 0; n < stop; n++) begin
        if ($urandom_range(3) == 0) push_byte(8'($urandom));
        else push_byte(($urandom_range(1) == 1) ? 8'h00 : 8'h01);
      end
      if ($urandom_range(9) == 0) unit_q[unit_q.size() - 1].eob = 1'b1;
    end
    // Cut the unit at a random byte and mark the buffer end there.
    if (force_cut || $urandom_range(99) < 4) begin
      cut = $urandom_range(unit_q.size() - 1);
      while (unit_q.size() > cut + 1) void'(unit_q.pop_back());
      unit_q[unit_q.size() - 1].eob = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int  sent;
    bit  paused;
    reset_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Video packet, length 5, no header data: two payload bytes, 0xFF then
    // 0x00, the second one closing the packet.
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h01, 1'b0, ChkNone);
    add_row(IdVideoLo, 1'b0, ChkNone);
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h05, 1'b0, ChkNone);
    add_row(8'h80, 1'b0, ChkNone);
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'hFF, 1'b0, ChkResult, 8'hFF, 1'b0);
    add_row(8'h00, 1'b0, ChkResult, 8'h00, 1'b1);
    // Unhandled id, then the end code: nothing comes out.
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h01, 1'b0, ChkNone);
    add_row(8'hBD, 1'b0, ChkNone);
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h00, 1'b0, ChkNone);
    add_row(8'h01, 1'b0, ChkNone);
    add_row(IdEnd, 1'b0, ChkNone);
    // Last video id with the buffer end on it, then a 0xFF buffer end.
    add_row(8'h00, 1'b0, ChkPredict);
    add_row(8'h00, 1'b0, ChkPredict);
    add_row(8'h01, 1'b0, ChkPredict);
    add_row(IdVideoHi, 1'b1, ChkPredict);
    add_row(8'hFF, 1'b1, ChkPredict);

    foreach (dir_rows[i])
      send_item(dir_rows[i].b, dir_rows[i].eob, dir_rows[i].mode,
                dir_rows[i].xb, dir_rows[i].xe);
    n_dir = dir_rows.size();
    drain_results();

    // Random stream, with a calm stretch and one more full drain midway.
    sent   = 0;
    paused = 1'b0;
    while (sent < RandItems) begin
      calm <= (sent >= 300 && sent < 650);
      if (!paused && sent >= 800) begin
        paused = 1'b1;
        drain_results();
      end
      gen_unit();
      foreach (unit_q[i]) begin
        send_item(unit_q[i].b, unit_q[i].eob, ChkPredict, 8'h00, 1'b0);
        sent++;
      end
    end
    in_valid_i <= 1'b0;
    // Let the monitor record the last accepted byte before looking at the queue.
    @(posedge clk_i);

    // Wait out the outstanding payload bytes, then the pipeline depth.
    while (es_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (es_expected.size() != 0) begin
      $error("%0d expected payload bytes never arrived", es_expected.size());
      n_err++;
    end

    $display("Run covered %0d stream bytes (%0d in the directed table), %0d buffer ends;",
             n_bytes, n_dir, n_eob);
    $display("%0d video payload bytes came out and were compared.", n_es);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: program_stream_video_extractor.f
+incdir+rtl/core
rtl/core/psve_pkg.sv
rtl/core/psve_parser.sv
rtl/core/psve_out_buf.sv
rtl/core/program_stream_video_extractor.sv
dv/tb_program_stream_video_extractor.sv
